// ===== hw/rtl/bu3x_pkg.sv =====
// ----------------------------------------------------------------------------
// bu3x_pkg : shared definitions for the 3x bilinear upscaler
// Widths, register indexes and the per-component blend function.
// ----------------------------------------------------------------------------
package bu3x_pkg;

	localparam int unsigned MAX_SOURCE_WIDTH_DEF = 512;
	localparam int unsigned CHANNELS     = 3;
	localparam int unsigned COMP_W       = 8;
	localparam int unsigned OUT_X_W      = 11;
	localparam int unsigned OUT_Y_W      = 14;
	localparam int unsigned SRC_W_REG_W  = 10;
	localparam int unsigned SRC_H_REG_W  = 13;
	localparam int unsigned ROW_W        = 12;
	localparam int unsigned HEIGHT_LIMIT = 4096;
	localparam int unsigned SRC_W_RESET  = 320;
	localparam int unsigned SRC_H_RESET  = 240;
	localparam int unsigned PADDR_W      = 3;
	localparam int unsigned PDATA_W      = 32;

	// weighted sum of four components peaks at 9 * 255
	localparam int unsigned SUM_W      = 12;
	// floor(s / 9) == (s * 7282) >> 16 for every s below 2304
	localparam int unsigned RECIP_W    = 13;
	localparam int unsigned DIV9_RECIP = 7282;
	localparam int unsigned DIV9_SHIFT = 16;

	typedef enum logic {
		REG_SRC_WIDTH  = 1'b0,
		REG_SRC_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [CHANNELS-1:0][COMP_W-1:0] pix_t;
	typedef logic [1:0] sub_t;

	// a: block pixel, b: right, c: lower, d: lower-right
	function automatic logic [SUM_W-1:0] blend(
		input logic [COMP_W-1:0] a,
		input logic [COMP_W-1:0] b,
		input logic [COMP_W-1:0] c,
		input logic [COMP_W-1:0] d,
		input sub_t dy,
		input sub_t dx
	);
		logic [3:0] wy0, wy1, wx0, wx1;
		logic [3:0] w00, w01, w10, w11;
		wy0 = 4'd3 - {2'b00, dy};
		wy1 = {2'b00, dy};
		wx0 = 4'd3 - {2'b00, dx};
		wx1 = {2'b00, dx};
		w00 = wy0 * wx0;
		w01 = wy0 * wx1;
		w10 = wy1 * wx0;
		w11 = wy1 * wx1;
		return (SUM_W'(a) * SUM_W'(w00)) + (SUM_W'(b) * SUM_W'(w01))
			+ (SUM_W'(c) * SUM_W'(w10)) + (SUM_W'(d) * SUM_W'(w11));
	endfunction

endpackage

// ===== hw/rtl/bu3x_ifs.sv =====
// ----------------------------------------------------------------------------
// bu3x interfaces : source pixel and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface bu3x_pix_if;
	logic                         valid;
	logic                         ready;
	logic [bu3x_pkg::COMP_W-1:0]  comp_red;
	logic [bu3x_pkg::COMP_W-1:0]  comp_green;
	logic [bu3x_pkg::COMP_W-1:0]  comp_blue;

	modport source (output valid, output comp_red, output comp_green, output comp_blue,
		input ready);
	modport sink (input valid, input comp_red, input comp_green, input comp_blue,
		output ready);
endinterface

interface bu3x_res_if;
	logic                         valid;
	logic                         ready;
	logic [bu3x_pkg::OUT_X_W-1:0] out_x;
	logic [bu3x_pkg::OUT_Y_W-1:0] out_y;
	logic [bu3x_pkg::COMP_W-1:0]  out_red;
	logic [bu3x_pkg::COMP_W-1:0]  out_green;
	logic [bu3x_pkg::COMP_W-1:0]  out_blue;
	logic                         run_end;

	modport source (output valid, output out_x, output out_y, output out_red,
		output out_green, output out_blue, output run_end, input ready);
	modport sink (input valid, input out_x, input out_y, input out_red,
		input out_green, input out_blue, input run_end, output ready);
endinterface

// ===== hw/rtl/bilinear_upscale_by_three_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_upscale_by_three_core : streaming 3x bilinear RGB upscaler
// Source pixels in raster order; each 3x3 output block is emitted once its
// right, lower and lower-right neighbours are in. Edges replicate.
// ----------------------------------------------------------------------------
//  channel  dir  beat                                  width
//  pix      in   comp_red/green/blue                   3 x 8
//  res      out  out_x, out_y, out_red/green/blue,     11 + 14 + 3 x 8 + 1
//                run_end
//  apb      in   source_width @ 0x0, source_height @ 0x4  10 / 13
//
//  One result per cycle unless res.ready is low or no block is pending,
//  from a single shared blend datapath: 9 results per source pixel in
//  steady state, 18 on the last column or the last row, 36 on the last
//  row's last column, none on the first row. The previous source row
//  sits in one registered-read RAM, read and rewritten at the same
//  column on the accept edge. Reset clears control and left_q/ul_q only;
//  the row RAM needs no clearing pass (row 0 writes every column before
//  it is read). One input beat is buffered while a block is in flight;
//  res.ready low freezes the whole output side.
// ----------------------------------------------------------------------------
module bilinear_upscale_by_three_core #(
	parameter int unsigned MAX_SOURCE_WIDTH = bu3x_pkg::MAX_SOURCE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bu3x_pkg::PADDR_W-1:0]  paddr,
	input  logic [bu3x_pkg::PDATA_W-1:0]  pwdata,
	output logic [bu3x_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	bu3x_pix_if.sink                      pix,
	bu3x_res_if.source                    res
);
	import bu3x_pkg::*;

	localparam int unsigned CW  = $clog2(MAX_SOURCE_WIDTH);
	localparam int unsigned EW  = (CW + 1 > SRC_W_REG_W) ? CW + 1 : SRC_W_REG_W;
	localparam int unsigned XFW = CW + 2;
	localparam int unsigned PW  = SUM_W + RECIP_W;

	// ---------------- configuration registers ----------------
	logic [SRC_W_REG_W-1:0] src_width_q;
	logic [SRC_H_REG_W-1:0] src_height_q;
	logic                   cfg_wr;
	reg_idx_t               cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_W_REG_W'(SRC_W_RESET);
			src_height_q <= SRC_H_REG_W'(SRC_H_RESET);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_SRC_WIDTH:  src_width_q  <= pwdata[SRC_W_REG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[SRC_H_REG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_q);
		endcase
	end

	// clamped geometry
	logic [EW-1:0]          eff_w;
	logic [SRC_H_REG_W-1:0] eff_h;

	always_comb begin
		eff_w = EW'(src_width_q);
		if (eff_w < EW'(2))
			eff_w = EW'(2);
		else if (eff_w > EW'(MAX_SOURCE_WIDTH))
			eff_w = EW'(MAX_SOURCE_WIDTH);
		eff_h = src_height_q;
		if (eff_h < SRC_H_REG_W'(2))
			eff_h = SRC_H_REG_W'(2);
		else if (eff_h > SRC_H_REG_W'(HEIGHT_LIMIT))
			eff_h = SRC_H_REG_W'(HEIGHT_LIMIT);
	end

	// ---------------- input position ----------------
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic             in_acc;
	logic             last_col, last_row;
	pix_t             cur_in;

	assign in_acc   = pix.valid && pix.ready;
	assign last_col = (EW'(col_q) == eff_w - EW'(1));
	assign last_row = (SRC_H_REG_W'(row_q) == eff_h - SRC_H_REG_W'(1));
	assign cur_in   = {pix.comp_blue, pix.comp_green, pix.comp_red};

	// any register write restarts the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// ---------------- upper row RAM ----------------
	// read-before-write at the same column: old row comes out, new goes in
	pix_t mem [MAX_SOURCE_WIDTH];
	pix_t up_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			up_s1      <= mem[col_q];
			mem[col_q] <= cur_in;
		end
	end

	// ---------------- stage 1: accepted beat ----------------
	logic             valid_s1;
	pix_t             cur_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             last_col_s1, last_row_s1;
	logic             take_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_acc)
			valid_s1 <= 1'b1;
		else if (take_job)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_s1      <= cur_in;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	// ---------------- block sequencer ----------------
	// mask bit 0: up-left block, 1: up block (last col),
	// 2: left block (last row), 3: own block (last row and col)
	logic [3:0]       mask_q;
	sub_t             dy_q, dx_q;
	pix_t             left_q, ul_q;
	pix_t             j_cur_q, j_up_q, j_left_q, j_ul_q;
	logic [CW-1:0]    j_col_q;
	logic [ROW_W-1:0] j_row_q;
	logic [3:0]       cur_blk, mask_rest;
	logic             job_busy, job_last, step;
	logic             adv_s2, adv_s3;
	logic             r_ge1, c_ge1;

	assign job_busy  = |mask_q;
	assign cur_blk   = mask_q & (~mask_q + 4'd1);
	assign mask_rest = mask_q & ~cur_blk;
	assign job_last  = (dy_q == 2'd2) && (dx_q == 2'd2) && (mask_rest == 4'd0);
	assign step      = adv_s2 && job_busy;
	assign take_job  = valid_s1 && (!job_busy || (job_last && step));
	assign pix.ready = !valid_s1 || take_job;
	assign r_ge1     = (row_s1 != '0);
	assign c_ge1     = (col_s1 != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			dy_q   <= '0;
			dx_q   <= '0;
			left_q <= '0;
			ul_q   <= '0;
		end else if (take_job) begin
			mask_q <= {last_row_s1 & last_col_s1, last_row_s1 & c_ge1,
				r_ge1 & last_col_s1, r_ge1 & c_ge1};
			dy_q   <= '0;
			dx_q   <= '0;
			left_q <= cur_s1;
			ul_q   <= up_s1;
		end else if (step) begin
			if (dx_q == 2'd2) begin
				dx_q <= '0;
				if (dy_q == 2'd2) begin
					dy_q   <= '0;
					mask_q <= mask_rest;
				end else begin
					dy_q <= dy_q + 2'd1;
				end
			end else begin
				dx_q <= dx_q + 2'd1;
			end
		end
	end

	// neighbours as they were when this beat was taken
	always_ff @(posedge clk) begin
		if (take_job) begin
			j_cur_q  <= cur_s1;
			j_up_q   <= up_s1;
			j_left_q <= left_q;
			j_ul_q   <= ul_q;
			j_col_q  <= col_s1;
			j_row_q  <= row_s1;
		end
	end

	// corner pixels and origin of the block in progress
	pix_t             pa, pb, pc, pd;
	logic [CW-1:0]    bx;
	logic [ROW_W-1:0] by;

	always_comb begin
		priority if (mask_q[0]) begin
			pa = j_ul_q;   pb = j_up_q;  pc = j_left_q; pd = j_cur_q;
			bx = j_col_q - CW'(1);
			by = j_row_q - ROW_W'(1);
		end else if (mask_q[1]) begin
			pa = j_up_q;   pb = j_up_q;  pc = j_cur_q;  pd = j_cur_q;
			bx = j_col_q;
			by = j_row_q - ROW_W'(1);
		end else if (mask_q[2]) begin
			pa = j_left_q; pb = j_cur_q; pc = j_left_q; pd = j_cur_q;
			bx = j_col_q - CW'(1);
			by = j_row_q;
		end else begin
			pa = j_cur_q;  pb = j_cur_q; pc = j_cur_q;  pd = j_cur_q;
			bx = j_col_q;
			by = j_row_q;
		end
	end

	logic [XFW-1:0]     x_full;
	logic [OUT_Y_W-1:0] y_full;

	assign x_full = XFW'({bx, 1'b0}) + XFW'(bx) + XFW'(dx_q);
	assign y_full = OUT_Y_W'({by, 1'b0}) + OUT_Y_W'(by) + OUT_Y_W'(dy_q);

	// ---------------- stage 2: weighted sums ----------------
	logic                             valid_s2, end_s2;
	logic [CHANNELS-1:0][SUM_W-1:0]   sum_s2;
	logic [OUT_X_W-1:0]               x_s2;
	logic [OUT_Y_W-1:0]               y_s2;

	assign adv_s3 = !res.valid || res.ready;
	assign adv_s2 = !valid_s2 || adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv_s2)
			valid_s2 <= job_busy;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int k = 0; k < CHANNELS; k++)
				sum_s2[k] <= blend(pa[k], pb[k], pc[k], pd[k], dy_q, dx_q);
			x_s2   <= OUT_X_W'(x_full);
			y_s2   <= y_full;
			end_s2 <= job_last;
		end
	end

	// ---------------- stage 3: divide by nine, output register ----------------
	logic [CHANNELS-1:0][PW-1:0]     prod;
	logic [CHANNELS-1:0][COMP_W-1:0] quot;

	always_comb begin
		for (int k = 0; k < CHANNELS; k++) begin
			prod[k] = PW'(sum_s2[k]) * PW'(DIV9_RECIP);
			quot[k] = prod[k][DIV9_SHIFT +: COMP_W];
		end
	end

	logic valid_s3;

	assign res.valid = valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv_s3)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			res.out_x     <= x_s2;
			res.out_y     <= y_s2;
			res.out_red   <= quot[0];
			res.out_green <= quot[1];
			res.out_blue  <= quot[2];
			res.run_end   <= end_s2;
		end
	end

	// ---------------- assertions ----------------
	a_beat_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted beat not held in stage 1");

	a_s1_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !take_job && !in_acc) |=> ($stable(cur_s1) && $stable(up_s1)))
		else $error("waiting beat or its upper pixel changed");

	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_busy |-> (dy_q != 2'd3 && dx_q != 2'd3))
		else $error("sub-position out of range");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		EW'(col_q) < eff_w)
		else $error("column counter beyond row width");

endmodule
